// ----- rtl/srwbc_pkg.sv -----
// Shared types and constants of the sorted register write burst coalescer.
`default_nettype none
package srwbc_pkg;

	// Number of cells in the sorted chain.
	localparam int unsigned CAPACITY = 32;
	localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
	localparam int unsigned REG_W    = 8;
	localparam int unsigned DATA_W   = 8;
	localparam int unsigned DEV_W    = 7;

	// Input function codes.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_FULL  = 2'd1,
		KIND_BURST = 2'd2,
		KIND_EMPTY = 2'd3
	} kind_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_FLUSH = 1'b1
	} state_t;

	// Commands broadcast to every cell of the chain.
	typedef enum logic [1:0] {
		CMD_HOLD   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_SHIFT  = 2'd2
	} cmd_t;

	// One buffered register write.
	typedef struct packed {
		logic [REG_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} entry_t;

	// Control word shared by all cells.
	typedef struct packed {
		cmd_t   cmd;
		entry_t ins;
	} cell_ctl_t;

	// Registered result word.
	typedef struct packed {
		kind_t             kind;
		logic [DEV_W-1:0]  bus_device;
		logic [REG_W-1:0]  start_reg;
		logic [DATA_W-1:0] byte_out;
		logic              burst_begin;
		logic              burst_end;
		logic              last;
	} rsp_t;

endpackage
`default_nettype wire

// ----- rtl/srwbc_if.sv -----
// Valid/ready channel interfaces for requests, results and configuration.
`default_nettype none
interface srwbc_req_if;
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [srwbc_pkg::REG_W-1:0]  reg_number;
	logic [srwbc_pkg::DATA_W-1:0] write_data;

	modport source (output valid, output func, output reg_number, output write_data,
		input ready);
	modport sink (input valid, input func, input reg_number, input write_data,
		output ready);
endinterface

interface srwbc_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                kind;
	logic [srwbc_pkg::DEV_W-1:0]  bus_device;
	logic [srwbc_pkg::REG_W-1:0]  start_reg;
	logic [srwbc_pkg::DATA_W-1:0] byte_out;
	logic                      burst_begin;
	logic                      burst_end;
	logic                      last;

	modport source (output valid, output kind, output bus_device, output start_reg,
		output byte_out, output burst_begin, output burst_end, output last, input ready);
	modport sink (input valid, input kind, input bus_device, input start_reg,
		input byte_out, input burst_begin, input burst_end, input last, output ready);
endinterface

interface srwbc_cfg_if;
	logic                     valid;
	logic                     ready;
	logic [srwbc_pkg::DEV_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/sorted_register_write_burst_coalescer.sv -----
// Top level: sorted write buffer built as a chain of cells, with burst flush control.
// A write is taken and its acknowledge sits in the output register from the next cycle;
// writes can follow every cycle while results are taken and no flush is under way.
// A flush is accepted first, with no word, then gives one burst word per cycle while results
// are taken, as the chain shifts toward cell 0. An empty flush gives one word.
// Reset clears the fill count, state, first-word flag, result valid flag and device address, not the cells.
`default_nettype none
module sorted_register_write_burst_coalescer (
	input  wire         clk,
	input  wire         arst_n,
	srwbc_cfg_if.sink   cfg,
	srwbc_req_if.sink   req,
	srwbc_rsp_if.source rsp
);
	import srwbc_pkg::*;

	localparam int unsigned NXT = (CAPACITY > 1) ? 1 : 0;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [DEV_W-1:0]    dev_q;
	logic                first_q, first_d;
	logic [REG_W-1:0]    prev_q, prev_d;
	logic [REG_W-1:0]    start_q, start_d;
	logic                rsp_valid_q;
	rsp_t                rsp_q, rsp_d;
	logic                load_out;
	logic                out_free;
	cell_ctl_t           ctl;
	entry_t              cells [CAPACITY];
	logic                shifts [CAPACITY];
	entry_t              head, nxt;
	logic                is_begin, is_end, is_last;

	// Configuration register.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q <= '0;
		end else if (cfg.valid) begin
			dev_q <= cfg.data;
		end
	end

	// Chain of cells; cell 0 is the head of the sorted order.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_e, right_e;
		logic   left_s;
		if (i == 0) begin : g_first
			assign left_e = cells[0];
			assign left_s = 1'b0;
		end else begin : g_mid
			assign left_e = cells[i-1];
			assign left_s = shifts[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign right_e = cells[i];
		end else begin : g_inner
			assign right_e = cells[i+1];
		end
		srwbc_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (count_q > CNT_W'(i)),
			.left_shift  (left_s),
			.left_entry  (left_e),
			.right_entry (right_e),
			.entry_q     (cells[i]),
			.shift       (shifts[i])
		);
	end

	assign head     = cells[0];
	assign nxt      = cells[NXT];
	assign out_free = !rsp_valid_q || rsp.ready;

	// Burst boundaries: consecutive means the next register is one higher, no wrap.
	assign is_last  = (count_q == CNT_W'(1));
	assign is_begin = first_q || ({1'b0, head.key} != ({1'b0, prev_q} + 9'd1));
	assign is_end   = is_last || ({1'b0, nxt.key} != ({1'b0, head.key} + 9'd1));

	// Next state, chain command and result word.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		first_d   = first_q;
		prev_d    = prev_q;
		start_d   = start_q;
		load_out  = 1'b0;
		rsp_d     = '0;
		ctl.cmd   = CMD_HOLD;
		ctl.ins   = '{key: req.reg_number, data: req.write_data};
		req.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = out_free;
				if (req.valid && out_free) begin
					load_out   = 1'b1;
					rsp_d.last = 1'b1;
					if (req.func == FUNC_WRITE) begin
						if (count_q == CNT_W'(CAPACITY)) begin
							rsp_d.kind = KIND_FULL;
						end else begin
							rsp_d.kind = KIND_ACK;
							ctl.cmd    = CMD_INSERT;
							count_d    = count_q + CNT_W'(1);
						end
					end else if (count_q == '0) begin
						rsp_d.kind = KIND_EMPTY;
					end else begin
						load_out   = 1'b0;
						rsp_d.last = 1'b0;
						first_d    = 1'b1;
						state_d    = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					load_out          = 1'b1;
					rsp_d.kind        = KIND_BURST;
					rsp_d.bus_device  = dev_q;
					rsp_d.start_reg   = is_begin ? head.key : start_q;
					rsp_d.byte_out    = head.data;
					rsp_d.burst_begin = is_begin;
					rsp_d.burst_end   = is_end;
					rsp_d.last        = is_last;
					ctl.cmd           = CMD_SHIFT;
					count_d           = count_q - CNT_W'(1);
					prev_d            = head.key;
					start_d           = rsp_d.start_reg;
					first_d           = 1'b0;
					if (is_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			first_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			first_q <= first_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Burst tracking and result payload.
	always_ff @(posedge clk) begin
		prev_q  <= prev_d;
		start_q <= start_d;
		if (load_out) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.kind        = rsp_q.kind;
	assign rsp.bus_device  = rsp_q.bus_device;
	assign rsp.start_reg   = rsp_q.start_reg;
	assign rsp.byte_out    = rsp_q.byte_out;
	assign rsp.burst_begin = rsp_q.burst_begin;
	assign rsp.burst_end   = rsp_q.burst_end;
	assign rsp.last        = rsp_q.last;

endmodule
`default_nettype wire

// ----- rtl/srwbc_cell.sv -----
// One cell of the sorted chain: holds a single entry and trades it with its neighbors.
`default_nettype none
module srwbc_cell (
	input  wire                   clk,
	input  wire srwbc_pkg::cell_ctl_t ctl,
	input  wire                   occupied,
	input  wire                   left_shift,
	input  wire srwbc_pkg::entry_t left_entry,
	input  wire srwbc_pkg::entry_t right_entry,
	output srwbc_pkg::entry_t     entry_q,
	output logic                  shift
);
	import srwbc_pkg::*;

	// The entry moves right on insert when it sorts strictly after the new word.
	assign shift = occupied && (entry_q.key > ctl.ins.key);

	// Payload only; occupancy follows from the fill count in the top level.
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_INSERT: begin
				if (left_shift) begin
					entry_q <= left_entry;
				end else if (shift || !occupied) begin
					entry_q <= ctl.ins;
				end
			end
			CMD_SHIFT: begin
				entry_q <= right_entry;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- bench/tb_sorted_register_write_burst_coalescer.sv -----
// Testbench for the sorted register write burst coalescer: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_sorted_register_write_burst_coalescer;
	import srwbc_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int RANDOM_ITEMS = 160;

	// One row of the directed table; a row may repeat with a register stride.
	typedef struct {
		logic       func;
		logic [7:0] reg_n;
		logic [7:0] data;
		int         reps;
		int         step;
		int         dev;
		bit         typed;
		kind_t      tkind;
	} row_t;

	logic clk;
	logic arst_n;

	srwbc_cfg_if cfg_ch ();
	srwbc_req_if req_ch ();
	srwbc_rsp_if rsp_ch ();

	sorted_register_write_burst_coalescer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the sorted buffer and the device address.
	entry_t     shadow_entries [CAPACITY];
	int         shadow_fill = 0;
	logic [6:0] shadow_dev = '0;

	// Words still owed by the block, oldest first, and the words of the latest item.
	rsp_t words_due [$];
	rsp_t fresh_words [$];

	rsp_t seen_word;
	rsp_t owed_word;
	int   fail_count = 0;
	int   cycle_count = 0;
	int   rsp_hold = 0;
	bit   steady = 1'b0;

	row_t directed_plan [0:18];

	// Clock with a 4 ns period.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Random gap length: mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Computes the words one accepted item causes and updates the shadow buffer.
	task automatic sort_and_coalesce(input logic f, input logic [7:0] rn, input logic [7:0] wd);
		int         pos;
		int         i;
		rsp_t       word;
		logic [7:0] run_start;
		fresh_words.delete();
		word = '0;
		word.last = 1'b1;
		run_start = '0;
		if (f == FUNC_WRITE) begin
			if (shadow_fill >= CAPACITY) begin
				word.kind = KIND_FULL;
				fresh_words.push_back(word);
				return;
			end
			// The new write goes after every entry with an equal or smaller register.
			pos = shadow_fill;
			for (i = 0; i < shadow_fill; i++) begin
				if (shadow_entries[i].key > rn) begin
					pos = i;
					break;
				end
			end
			for (i = shadow_fill; i > pos; i--)
				shadow_entries[i] = shadow_entries[i - 1];
			shadow_entries[pos].key = rn;
			shadow_entries[pos].data = wd;
			shadow_fill++;
			word.kind = KIND_ACK;
			fresh_words.push_back(word);
		end else if (shadow_fill == 0) begin
			word.kind = KIND_EMPTY;
			fresh_words.push_back(word);
		end else begin
			// Bursts break wherever the next register is not exactly one higher, with no wrap.
			for (i = 0; i < shadow_fill; i++) begin
				word = '0;
				word.kind = KIND_BURST;
				word.bus_device = shadow_dev;
				word.byte_out = shadow_entries[i].data;
				word.burst_begin = 1'b1;
				if (i > 0) begin
					if (int'(shadow_entries[i].key) == int'(shadow_entries[i - 1].key) + 1)
						word.burst_begin = 1'b0;
				end
				if (word.burst_begin)
					run_start = shadow_entries[i].key;
				word.start_reg = run_start;
				word.burst_end = 1'b1;
				if (i + 1 < shadow_fill) begin
					if (int'(shadow_entries[i + 1].key) == int'(shadow_entries[i].key) + 1)
						word.burst_end = 1'b0;
				end
				word.last = (i + 1 == shadow_fill);
				fresh_words.push_back(word);
			end
			shadow_fill = 0;
		end
	endtask

	// Sends one request word after a random gap and books its expected results.
	task automatic send_word(input logic f, input logic [7:0] rn, input logic [7:0] wd,
		input bit typed, input kind_t tk);
		int   g;
		rsp_t fixed;
		g = pick_gap();
		if (g > 0) begin
			req_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.reg_number <= rn;
		req_ch.write_data <= wd;
		do @(posedge clk); while (!req_ch.ready);
		sort_and_coalesce(f, rn, wd);
		if (typed) begin
			fixed = '0;
			fixed.kind = tk;
			fixed.last = 1'b1;
			words_due.push_back(fixed);
		end else begin
			foreach (fresh_words[i])
				words_due.push_back(fresh_words[i]);
		end
	endtask

	// Writes the device address once the block has drained.
	task automatic set_device(input logic [6:0] v);
		req_ch.valid <= 1'b0;
		while (words_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		shadow_dev = v;
	endtask

	// Result side: random stalls on ready.
	always @(posedge clk) begin
		if (rsp_hold > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold <= rsp_hold - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
			if ($urandom_range(0, 1) == 0)
				rsp_hold <= pick_gap();
		end
	end

	// Every accepted result word is compared with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			seen_word = {kind_t'(rsp_ch.kind), rsp_ch.bus_device, rsp_ch.start_reg,
				rsp_ch.byte_out, rsp_ch.burst_begin, rsp_ch.burst_end, rsp_ch.last};
			if (words_due.size() == 0) begin
				$display("%0t: unexpected word kind=%0d dev=%0d start=%0d byte=%0d b=%0d e=%0d l=%0d",
					$time, seen_word.kind, seen_word.bus_device, seen_word.start_reg,
					seen_word.byte_out, seen_word.burst_begin, seen_word.burst_end, seen_word.last);
				fail_count++;
			end else begin
				owed_word = words_due.pop_front();
				if (seen_word !== owed_word) begin
					$display("%0t: expected kind=%0d dev=%0d start=%0d byte=%0d b=%0d e=%0d l=%0d",
						$time, owed_word.kind, owed_word.bus_device, owed_word.start_reg,
						owed_word.byte_out, owed_word.burst_begin, owed_word.burst_end,
						owed_word.last);
					$display("%0t: actual   kind=%0d dev=%0d start=%0d byte=%0d b=%0d e=%0d l=%0d",
						$time, seen_word.kind, seen_word.bus_device, seen_word.start_reg,
						seen_word.byte_out, seen_word.burst_begin, seen_word.burst_end,
						seen_word.last);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Reset, directed table, random traffic, then drain and report.
	initial begin
		int         sent;
		int         group;
		int         nwr;
		int         span;
		int         base;
		int         r;
		int         k;
		sent = 0;
		group = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_WRITE;
		req_ch.reg_number = '0;
		req_ch.write_data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		rsp_ch.ready = 1'b0;

		// Directed rows: empty flush, wrap-free adjacency, head insertion, full buffer, repeats.
		directed_plan = '{
			'{FUNC_FLUSH, 8'd0,   8'h00, 1,  0, -1,  1'b1, KIND_EMPTY},
			'{FUNC_WRITE, 8'd255, 8'hFF, 1,  0, -1,  1'b1, KIND_ACK},
			'{FUNC_WRITE, 8'd0,   8'h00, 1,  0, -1,  1'b1, KIND_ACK},
			'{FUNC_WRITE, 8'd254, 8'hA5, 1,  0, -1,  1'b1, KIND_ACK},
			'{FUNC_WRITE, 8'd255, 8'h5A, 1,  0, -1,  1'b1, KIND_ACK},
			'{FUNC_WRITE, 8'd1,   8'h3C, 1,  0, -1,  1'b1, KIND_ACK},
			'{FUNC_WRITE, 8'd0,   8'hC3, 1,  0, -1,  1'b1, KIND_ACK},
			'{FUNC_FLUSH, 8'd0,   8'h00, 1,  0, -1,  1'b0, KIND_ACK},
			'{FUNC_FLUSH, 8'd0,   8'h00, 1,  0, -1,  1'b1, KIND_EMPTY},
			'{FUNC_WRITE, 8'd128, 8'h00, 32, 1, 127, 1'b1, KIND_ACK},
			'{FUNC_WRITE, 8'd7,   8'h11, 1,  0, -1,  1'b1, KIND_FULL},
			'{FUNC_FLUSH, 8'd0,   8'h00, 1,  0, -1,  1'b0, KIND_ACK},
			'{FUNC_WRITE, 8'd200, 8'h80, 3,  2, -1,  1'b1, KIND_ACK},
			'{FUNC_WRITE, 8'd201, 8'h01, 1,  0, -1,  1'b1, KIND_ACK},
			'{FUNC_FLUSH, 8'd0,   8'h00, 1,  0, -1,  1'b0, KIND_ACK},
			'{FUNC_WRITE, 8'd10,  8'h00, 32, 0, 0,   1'b1, KIND_ACK},
			'{FUNC_WRITE, 8'd10,  8'hFF, 1,  0, -1,  1'b1, KIND_FULL},
			'{FUNC_FLUSH, 8'd0,   8'h00, 1,  0, -1,  1'b0, KIND_ACK},
			'{FUNC_FLUSH, 8'd0,   8'h00, 1,  0, -1,  1'b1, KIND_EMPTY}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].dev >= 0)
				set_device(7'(directed_plan[i].dev));
			for (k = 0; k < directed_plan[i].reps; k++)
				send_word(directed_plan[i].func, 8'(directed_plan[i].reg_n + k * directed_plan[i].step),
					8'(directed_plan[i].data + k), directed_plan[i].typed, directed_plan[i].tkind);
		end

		// Random groups: a run of writes over a chosen register window, closed by a flush.
		while (sent < RANDOM_ITEMS) begin
			if (group % 3 == 0) begin
				case (group / 3)
					0: begin
						set_device(7'd0);
					end
					1: begin
						set_device(7'h7F);
					end
					default: begin
						set_device(7'($urandom_range(0, 127)));
					end
				endcase
			end
			steady = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 9);
			if (r == 0)
				nwr = 0;
			else if (r <= 2)
				nwr = $urandom_range(30, 40);
			else
				nwr = $urandom_range(1, 12);
			case ($urandom_range(0, 2))
				0: begin
					span = 255;
				end
				1: begin
					span = $urandom_range(0, 6);
				end
				default: begin
					span = $urandom_range(10, 40);
				end
			endcase
			base = $urandom_range(0, 255 - span);
			for (k = 0; k < nwr; k++) begin
				// Now and then a flush breaks the run early.
				if ($urandom_range(0, 15) == 0) begin
					send_word(FUNC_FLUSH, 8'($urandom), 8'($urandom), 1'b0, KIND_ACK);
					sent++;
				end
				send_word(FUNC_WRITE, 8'(base + $urandom_range(0, span)), 8'($urandom),
					1'b0, KIND_ACK);
				sent++;
			end
			send_word(FUNC_FLUSH, 8'($urandom), 8'($urandom), 1'b0, KIND_ACK);
			sent++;
			group++;
		end

		// Drain everything still owed, then keep watching for stray words before the report.
		req_ch.valid <= 1'b0;
		while (words_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/srwbc_pkg.sv
rtl/srwbc_if.sv
rtl/srwbc_cell.sv
rtl/sorted_register_write_burst_coalescer.sv
bench/tb_sorted_register_write_burst_coalescer.sv
